// File: rtl/core/gfrs_pkg.sv
// Shared widths, payload structs and register codes for the gear indicator.
// No dependencies; every module of the block imports this package.
package gfrs_pkg;

  // Field widths of the stream words and registers.
  localparam int RPM_W      = 15;
  localparam int SPEED_W    = 12;
  localparam int SCALE_W    = 20;
  localparam int COUNT_W    = 3;
  localparam int RATIO_W    = 16;
  localparam int GEAR_W     = 3;

  // Product rpm * scale, and the part left after the divide by 256.
  localparam int PROD_W     = RPM_W + SCALE_W;
  localparam int FRAC_DROP  = 8;
  localparam int NUM_W      = PROD_W - FRAC_DROP;

  // Divider: one quotient bit per stage, remainder as wide as the divisor.
  localparam int QUOT_W     = RATIO_W;
  localparam int REM_W      = SPEED_W;
  localparam int CMP_W      = SPEED_W + QUOT_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SCALE_W;

  // Stream word widths, padded to whole bytes.
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 24;

  localparam int MAX_GEARS_DEF = 6;

  localparam logic [RATIO_W-1:0] RATIO_MAX   = '1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(18678);

  // Register indexes; gear ratio registers follow the base one after another.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO_SCALE     = 3'd0,
    REG_GEAR_COUNT      = 3'd1,
    REG_GEAR_RATIO_BASE = 3'd2
  } cfg_reg_e;

  // Multiplier stage output.
  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [SPEED_W-1:0] speed;
    logic               zero;
  } prod_t;

  // One divider stage: partial remainder, dividend bits shifting out while
  // quotient bits shift in, the divisor, and the special-case flags.
  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [QUOT_W-1:0]  bits;
    logic [SPEED_W-1:0] dvs;
    logic               sat;
    logic               zero;
  } div_stage_t;

  // Divider output.
  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              sat;
    logic              zero;
  } quot_t;

endpackage

// File: rtl/core/gfrs_cfg_regs.sv
// Configuration register file of the gear indicator: scale, gear count and
// the gear ratio thresholds. Depends on gfrs_pkg.
module gfrs_cfg_regs import gfrs_pkg::*; #(
  parameter int MAX_GEARS = MAX_GEARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [SCALE_W-1:0]    scale_o,
  output logic [COUNT_W-1:0]    count_o,
  output logic [RATIO_W-1:0]    thr_o [MAX_GEARS]
);

  logic [SCALE_W-1:0] scale_q;
  logic [COUNT_W-1:0] count_q;

  // Scale and gear count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RATIO_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        REG_GEAR_COUNT:  count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // One threshold register per gear, each at its own index.
  for (genvar g = 0; g < MAX_GEARS; g++) begin : g_thr
    logic [RATIO_W-1:0] thr_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        thr_q <= '0;
      end else if (cfg_we_i &&
                   cfg_idx_i == CFG_IDX_W'(REG_GEAR_RATIO_BASE) + CFG_IDX_W'(g)) begin
        thr_q <= cfg_data_i[RATIO_W-1:0];
      end
    end

    assign thr_o[g] = thr_q;
  end

  assign scale_o = scale_q;
  assign count_o = count_q;

endmodule

// File: rtl/core/gfrs_mul.sv
// Multiplier stage: rpm times scale, dropping the low 8 bits (the /256 of
// the ratio formula). Depends on gfrs_pkg.
module gfrs_mul import gfrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [RPM_W-1:0]   rpm_i,
  input  logic [SPEED_W-1:0] speed_i,
  input  logic [SCALE_W-1:0] scale_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output prod_t              out_o
);

  logic              vld_q;
  prod_t             prod_q;
  prod_t             prod_d;
  logic [PROD_W-1:0] full_prod;

  // Full product; the low fraction bits never reach the quotient.
  assign full_prod     = PROD_W'(rpm_i) * PROD_W'(scale_i);
  assign prod_d.num    = full_prod[PROD_W-1:FRAC_DROP];
  assign prod_d.speed  = speed_i;
  assign prod_d.zero   = (rpm_i == '0) || (speed_i == '0);

  assign in_ready_o = !vld_q || out_ready_i;

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = prod_q;

endmodule

// File: rtl/core/gfrs_div_pipe.sv
// Pipelined restoring divider: an overflow check stage, then one quotient bit
// per stage. Each stage holds its word while the next one is full and stalled.
// Depends on gfrs_pkg.
module gfrs_div_pipe import gfrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  prod_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output quot_t out_o
);

  localparam int NSTG = QUOT_W + 1;
  localparam int LAST = NSTG - 1;

  div_stage_t       st_q [NSTG];
  logic [NSTG-1:0]  vld_q;
  logic [NSTG:0]    rdy;
  div_stage_t       init_d;

  // A stage can load when it is empty or its word moves on this cycle.
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  // Overflow check: the quotient fits in 16 bits only when the dividend is
  // below divisor * 2^16. Then the top dividend bits start as the remainder.
  always_comb begin
    init_d.sat  = CMP_W'(in_i.num) >= {in_i.speed, {QUOT_W{1'b0}}};
    init_d.rem  = REM_W'(in_i.num[NUM_W-1:QUOT_W]);
    init_d.bits = in_i.num[QUOT_W-1:0];
    init_d.dvs  = in_i.speed;
    init_d.zero = in_i.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      st_q[0] <= init_d;
    end
  end

  // Quotient bit stages, most significant bit first.
  for (genvar k = 1; k < NSTG; k++) begin : g_step
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;
    div_stage_t     nxt;

    always_comb begin
      trial    = {st_q[k-1].rem, st_q[k-1].bits[QUOT_W-1]};
      diff     = trial - {1'b0, st_q[k-1].dvs};
      ge       = trial >= {1'b0, st_q[k-1].dvs};
      nxt      = st_q[k-1];
      nxt.rem  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      nxt.bits = {st_q[k-1].bits[QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_q[k-1]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign out_valid_o = vld_q[LAST];
  assign out_o.quot  = st_q[LAST].bits;
  assign out_o.sat   = st_q[LAST].sat;
  assign out_o.zero  = st_q[LAST].zero;

`ifndef ASSERT_OFF
  // A finished quotient that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAST] && !out_ready_i |=> vld_q[LAST] && $stable(st_q[LAST]))
    else $error("divider output changed while stalled");

  // Without overflow the final remainder is below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAST] && !st_q[LAST].sat |-> st_q[LAST].rem < st_q[LAST].dvs)
    else $error("divider remainder not reduced");
`endif

endmodule

// File: rtl/core/gfrs_gear_sel.sv
// Output stage: applies the zero and saturation cases to the quotient, picks
// the first gear whose threshold is exceeded and registers the result word.
// Depends on gfrs_pkg.
module gfrs_gear_sel import gfrs_pkg::*; #(
  parameter int MAX_GEARS = MAX_GEARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  quot_t              in_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [RATIO_W-1:0] thr_i [MAX_GEARS],
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [GEAR_W-1:0]  gear_o,
  output logic [RATIO_W-1:0] ratio_o
);

  logic               vld_q;
  logic [GEAR_W-1:0]  gear_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [RATIO_W-1:0] ratio_d;
  logic [GEAR_W-1:0]  gear_d;
  logic [COUNT_W-1:0] used;

  // Zero rpm or speed wins over overflow; overflow saturates.
  always_comb begin
    if (in_i.zero) begin
      ratio_d = '0;
    end else if (in_i.sat) begin
      ratio_d = RATIO_MAX;
    end else begin
      ratio_d = in_i.quot;
    end
  end

  // Gear count beyond the number of threshold registers is clipped.
  assign used = (count_i > COUNT_W'(MAX_GEARS)) ? COUNT_W'(MAX_GEARS) : count_i;

  // Walk from the last gear down so that the lowest exceeded gear wins.
  always_comb begin
    gear_d = '0;
    for (int i = MAX_GEARS - 1; i >= 0; i--) begin
      if (used > COUNT_W'(i) && ratio_d > thr_i[i]) begin
        gear_d = GEAR_W'(i + 1);
      end
    end
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      gear_q  <= gear_d;
      ratio_q <= ratio_d;
    end
  end

  assign out_valid_o = vld_q;
  assign gear_o      = gear_q;
  assign ratio_o     = ratio_q;

`ifndef ASSERT_OFF
  // A zero ratio exceeds no threshold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && ratio_q == '0 |-> gear_q == '0)
    else $error("gear reported for zero ratio");

  // The reported gear never names a threshold register that does not exist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> gear_q <= GEAR_W'(MAX_GEARS))
    else $error("gear beyond the threshold registers");
`endif

endmodule

// File: rtl/core/gear_from_rpm_and_speed_top.sv
// Top level of the calculated gear indicator: config registers, multiplier,
// pipelined divider and gear selection. Depends on gfrs_pkg and all gfrs_* modules.
//
//   channel  direction  handshake                    word
//   s_axis   in         s_axis_tvalid/s_axis_tready  engine_rpm, road_speed
//   m_axis   out        m_axis_tvalid/m_axis_tready  gear, measured_ratio
//   cfg      in         cfg_we_i (no back-pressure)  register index and data
//
// One word per cycle sustained while m_axis takes every word; the stages are
// one multiplier stage, one overflow check stage, 16 divider stages of one
// quotient bit each, and the registered output stage.
// Every stage keeps its own valid bit and loads whenever it is empty or drains,
// so a stall on m_axis fills the bubbles first and loses no word.
// Reset clears all valid bits and loads the register reset values.
module gear_from_rpm_and_speed_top import gfrs_pkg::*; #(
  parameter int MAX_GEARS = MAX_GEARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [14:0] engine_rpm, [26:15] road_speed
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [2:0] gear, [18:3] measured_ratio
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PAD_W = M_TDATA_W - RATIO_W - GEAR_W;

  logic [RPM_W-1:0]   rpm;
  logic [SPEED_W-1:0] speed;
  logic [SCALE_W-1:0] scale;
  logic [COUNT_W-1:0] count;
  logic [RATIO_W-1:0] thr [MAX_GEARS];

  logic               mul_valid;
  logic               mul_ready;
  prod_t              mul_word;
  logic               div_valid;
  logic               div_ready;
  quot_t              div_word;
  logic [GEAR_W-1:0]  gear;
  logic [RATIO_W-1:0] ratio;

  // Unpack the input word.
  assign rpm   = s_axis_tdata[RPM_W-1:0];
  assign speed = s_axis_tdata[RPM_W+SPEED_W-1:RPM_W];

  gfrs_cfg_regs #(
    .MAX_GEARS (MAX_GEARS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .scale_o    (scale),
    .count_o    (count),
    .thr_o      (thr)
  );

  gfrs_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .rpm_i       (rpm),
    .speed_i     (speed),
    .scale_i     (scale),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_o       (mul_word)
  );

  gfrs_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .in_i        (mul_word),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_word)
  );

  gfrs_gear_sel #(
    .MAX_GEARS (MAX_GEARS)
  ) u_sel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_i        (div_word),
    .count_i     (count),
    .thr_i       (thr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .gear_o      (gear),
    .ratio_o     (ratio)
  );

  // Pack the result word.
  assign m_axis_tdata = {{PAD_W{1'b0}}, ratio, gear};

endmodule
